>>> src/wav_riff_chunk_parser_defines.svh
// Assertion macros used by the parser's queue module.
`ifndef WAV_RIFF_CHUNK_PARSER_DEFINES_SVH
`define WAV_RIFF_CHUNK_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define WRC_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error(msg);
// Check a property at every edge, reset included.
`define WRC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) \
        else $error(msg);
`else
`define WRC_ASSERT(lbl, ck, rn, prop, msg)
`define WRC_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

>>> src/wrc_pkg.sv
package wrc_pkg;

    localparam int CFG_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int CHAN_W    = 16;
    localparam int RATE_W    = 32;
    localparam int TDATA_W   = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] MIN_FILE   = 32'd44;
    localparam logic [31:0] TAG_RIFF   = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE   = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT    = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA   = 32'h6174_6164;
    localparam logic [32:0] CHUNK_BASE = 33'd12;
    localparam logic [31:0] FMT_MIN    = 32'd16;

    // Bits of the found flags
    localparam int FL_TAGS = 0;
    localparam int FL_FMT  = 1;
    localparam int FL_DATA = 2;
    localparam int FL_FULL = 3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TAGS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FMT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_DATA   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_FMT   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_CHANS = 3'd6;
    localparam logic [STATUS_W-1:0] ST_ZERO_RATE = 3'd7;

    typedef struct packed {
        logic                item_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic                run_start;
        logic [STATUS_W-1:0] status;
        logic [CHAN_W-1:0]   channel_count;
        logic [RATE_W-1:0]   sample_rate;
        logic                last_result;
    } item_t;

    // Results caused by one accepted byte: a payload item, then a verdict
    typedef struct packed {
        logic  payload_valid;
        item_t payload;
        logic  verdict_valid;
        item_t verdict;
    } push_t;

    function automatic logic [STATUS_W-1:0] status_code(
        input logic [31:0] file_length,
        input logic [3:0]  flags,
        input logic [15:0] audio_format,
        input logic [15:0] channels,
        input logic [31:0] rate,
        input logic [15:0] bits
    );
        logic [STATUS_W-1:0] code;
        if (file_length < MIN_FILE)
            code = ST_SHORT;
        else if (!flags[FL_TAGS])
            code = ST_BAD_TAGS;
        else if (!flags[FL_FMT])
            code = ST_NO_FMT;
        else if (!flags[FL_DATA] || !flags[FL_FULL])
            code = ST_NO_DATA;
        else if (audio_format != 16'd1 || bits != 16'd16)
            code = ST_BAD_FMT;
        else if (channels < 16'd1 || channels > 16'd2)
            code = ST_BAD_CHANS;
        else if (rate == 32'd0)
            code = ST_ZERO_RATE;
        else
            code = ST_OK;
        return code;
    endfunction

endpackage

>>> src/wrc_front.sv
module wrc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [wrc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       accept,
    input  logic [wrc_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    output wrc_pkg::push_t             push
);

    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_PAD  = 3'd3;
    localparam logic [2:0] PH_STOP = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    localparam logic [31:0] RIFF_TAG_END = 32'd3;
    localparam logic [31:0] WAVE_TAG_END = 32'd11;
    localparam logic [31:0] HEAD_LEN     = 32'd8;
    localparam logic [31:0] SIZE_START   = 32'd4;

    logic [31:0] len_reg;
    logic [31:0] pos_reg,   pos_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] tag_reg,   tag_next;
    logic [31:0] size_reg,  size_next;
    logic [31:0] off_reg,   off_next;
    logic [15:0] fmt_reg,   fmt_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg,  rate_next;
    logic [15:0] bits_reg,  bits_next;
    logic [3:0]  flags_reg, flags_next;

    logic [32:0] pos_inc;
    logic [32:0] len_ext;
    logic [31:0] tag_in;
    logic [31:0] off_inc;
    logic        head_fits;

    assign cfg_ready = 1'b1;
    assign pos_inc   = {1'b0, pos_reg} + 33'd1;
    assign len_ext   = {1'b0, len_reg};
    assign tag_in    = {in_byte, tag_reg[31:8]};
    assign off_inc   = off_reg + 32'd1;
    assign head_fits = (pos_inc + {1'b0, HEAD_LEN}) <= len_ext;

    // Hold the file length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg <= cfg_data;
        end
    end

    // Advance the parse state by one byte
    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        tag_next   = tag_reg;
        size_next  = size_reg;
        off_next   = off_reg;
        fmt_next   = fmt_reg;
        chans_next = chans_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        flags_next = flags_reg;
        push       = '0;

        if (accept && phase_reg != PH_DONE)
        begin
            case (phase_reg)
                PH_RIFF:
                begin
                    tag_next = tag_in;
                    if (pos_reg == RIFF_TAG_END)
                    begin
                        if (tag_in == wrc_pkg::TAG_RIFF)
                            flags_next[wrc_pkg::FL_TAGS] = 1'b1;
                    end
                    else if (pos_reg == WAVE_TAG_END)
                    begin
                        if (tag_in != wrc_pkg::TAG_WAVE)
                            flags_next[wrc_pkg::FL_TAGS] = 1'b0;
                        if (len_reg < wrc_pkg::MIN_FILE || !flags_next[wrc_pkg::FL_TAGS])
                        begin
                            flags_next[wrc_pkg::FL_TAGS] = 1'b0;
                            phase_next = PH_STOP;
                        end
                        else if (wrc_pkg::CHUNK_BASE + {1'b0, HEAD_LEN} <= len_ext)
                        begin
                            phase_next = PH_HEAD;
                            off_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                end
                PH_HEAD:
                begin
                    if (off_reg < SIZE_START)
                        tag_next = tag_in;
                    else
                        size_next = {in_byte, size_reg[31:8]};
                    off_next = off_inc;
                    if (off_inc == HEAD_LEN)
                    begin
                        off_next = '0;
                        if (pos_inc + {1'b0, size_next} > len_ext)
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            if (tag_reg == wrc_pkg::TAG_DATA)
                            begin
                                flags_next[wrc_pkg::FL_DATA] = 1'b1;
                                flags_next[wrc_pkg::FL_FULL] = (size_next != '0);
                            end
                            if (size_next != '0)
                                phase_next = PH_BODY;
                            else if (head_fits)
                                phase_next = PH_HEAD;
                            else
                                phase_next = PH_STOP;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (tag_reg == wrc_pkg::TAG_DATA)
                    begin
                        push.payload_valid          = 1'b1;
                        push.payload.item_kind      = wrc_pkg::KIND_PAYLOAD;
                        push.payload.payload_byte   = in_byte;
                        push.payload.run_start      = (off_reg == '0);
                    end
                    else if (tag_reg == wrc_pkg::TAG_FMT && size_reg >= wrc_pkg::FMT_MIN
                             && off_reg < wrc_pkg::FMT_MIN)
                    begin
                        // Capture the fmt fields byte by byte
                        case (off_reg[3:0])
                            4'd0:  fmt_next[7:0]    = in_byte;
                            4'd1:  fmt_next[15:8]   = in_byte;
                            4'd2:  chans_next[7:0]  = in_byte;
                            4'd3:  chans_next[15:8] = in_byte;
                            4'd4:  rate_next[7:0]   = in_byte;
                            4'd5:  rate_next[15:8]  = in_byte;
                            4'd6:  rate_next[23:16] = in_byte;
                            4'd7:  rate_next[31:24] = in_byte;
                            4'd14: bits_next[7:0]   = in_byte;
                            4'd15:
                            begin
                                bits_next[15:8]             = in_byte;
                                flags_next[wrc_pkg::FL_FMT] = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    off_next = off_inc;
                    if (off_inc == size_reg)
                    begin
                        off_next = '0;
                        if (size_reg[0])
                            phase_next = PH_PAD;
                        else if (head_fits)
                            phase_next = PH_HEAD;
                        else
                            phase_next = PH_STOP;
                    end
                end
                PH_PAD:
                begin
                    if (head_fits)
                    begin
                        phase_next = PH_HEAD;
                        off_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                default: ;
            endcase

            // Saturate the byte count
            if (pos_reg != '1)
                pos_next = pos_inc[31:0];

            // Close the run with a verdict
            if (in_last)
            begin
                push.verdict_valid         = 1'b1;
                push.verdict.item_kind     = wrc_pkg::KIND_VERDICT;
                push.verdict.status        = wrc_pkg::status_code(len_reg, flags_next,
                                                 fmt_next, chans_next, rate_next, bits_next);
                push.verdict.channel_count = chans_next;
                push.verdict.sample_rate   = rate_next;
                push.verdict.last_result   = 1'b1;
                phase_next                 = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_RIFF;
            tag_reg   <= '0;
            size_reg  <= '0;
            off_reg   <= '0;
            fmt_reg   <= '0;
            chans_reg <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            size_reg  <= size_next;
            off_reg   <= off_next;
            fmt_reg   <= fmt_next;
            chans_reg <= chans_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            flags_reg <= flags_next;
        end
    end

endmodule

>>> src/wrc_queue.sv
`include "wav_riff_chunk_parser_defines.svh"

module wrc_queue #(
    parameter int DEPTH = wrc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wrc_pkg::push_t push,
    input  logic           pop,
    output wrc_pkg::item_t rd_item,
    output logic           rd_valid,
    output logic           has_room
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wrc_pkg::item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [1:0]       push_n;
    logic [PTR_W-1:0] wr_ptr_b;
    logic [CNT_W:0]   fill_after;
    wrc_pkg::item_t   first_item;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign push_n     = {1'b0, push.payload_valid} + {1'b0, push.verdict_valid};
    assign wr_ptr_b   = wrap_inc(wr_ptr_reg);
    assign first_item = push.payload_valid ? push.payload : push.verdict;
    assign rd_item    = mem[rd_ptr_reg];
    assign rd_valid   = (count_reg != '0);
    assign has_room   = (count_reg <= CNT_W'(DEPTH - 2));
    assign fill_after = {1'b0, count_reg} + (CNT_W+1)'(push_n);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push_n)
            2'd1:    wr_ptr_next = wr_ptr_b;
            2'd2:    wr_ptr_next = wrap_inc(wr_ptr_b);
            default: ;
        endcase
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store up to two requests per cycle, payload ahead of verdict
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= first_item;
        if (push_n == 2'd2)
            mem[wr_ptr_b] <= push.verdict;
    end

    `WRC_ASSERT_ALWAYS(a_count_bound, clk, count_reg <= CNT_W'(DEPTH), "queue count past depth")
    `WRC_ASSERT(a_no_overflow, clk, rst_n, fill_after <= (CNT_W+1)'(DEPTH), "queue overflow")
    `WRC_ASSERT(a_no_underflow, clk, rst_n, pop |-> (count_reg != '0), "pop from empty queue")

endmodule

>>> src/wrc_back.sv
module wrc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wrc_pkg::item_t              q_item,
    input  logic                        q_valid,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [wrc_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int PAD_W = wrc_pkg::TDATA_W - wrc_pkg::RATE_W - wrc_pkg::CHAN_W
                         - wrc_pkg::STATUS_W - 1 - wrc_pkg::BYTE_W;

    wrc_pkg::item_t item_reg;
    logic           valid_reg, valid_next;

    // Load the output register whenever the queue holds an item and the register is empty or being drained
    assign pop        = q_valid && (!valid_reg || m_axis_tready);
    assign valid_next = pop ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_item;
    end

    // Pack the result fields onto the bus
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, item_reg.sample_rate, item_reg.channel_count,
                            item_reg.status, item_reg.run_start, item_reg.payload_byte};
    assign m_axis_tuser  = item_reg.item_kind;
    assign m_axis_tlast  = item_reg.last_result;

endmodule

>>> src/wav_riff_chunk_parser.sv
// WAV file parser: walks the RIFF chunks of a byte stream and streams out
// the data chunk payload followed by a one-item verdict.
// Configuration: write the file length on cfg_data (cfg_valid/cfg_ready,
// always ready) before the first byte of a file.
// Input stream: one file byte per request on s_axis_tdata, s_axis_tlast on
// the final byte. Output stream: payload bytes (tuser 0, run start flag in
// tdata) and, after the final byte, a verdict (tuser 1, tlast 1) with
// status, channel count and sample rate.
// Each result passes through the result queue and the output register.
// Throughput: one byte per cycle while s_axis_tready is high; the parser
// updates all state as it accepts each byte, and a final byte that also
// carries payload yields two requests into the result queue, which the
// output register drains one per cycle while m_axis_tready is high.
// s_axis_tready drops while the result queue lacks room for two requests,
// so a stalled receiver backs up into the input.
// Reset clears the parse state, the file length, the queue and the output
// valid; after a verdict further bytes are taken and dropped until reset.
module wav_riff_chunk_parser #(
    parameter int QUEUE_DEPTH = wrc_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wrc_pkg::CFG_W-1:0]   cfg_data,       // file_length
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [wrc_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] file_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] payload_byte, [8] run_start, [11:9] status,
    // [27:12] channel_count, [59:28] sample_rate, [63:60] zero
    output logic [wrc_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tuser,   // [0] item_kind
    output logic                        m_axis_tlast
);

    wrc_pkg::push_t push;
    wrc_pkg::item_t q_item;
    logic           q_valid;
    logic           q_room;
    logic           pop;
    logic           accept;

    assign s_axis_tready = q_room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .push      (push)
    );

    wrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .has_room (q_room)
    );

    wrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> verif/wav_riff_chunk_parser_tb.sv
`timescale 1ns / 1ps

module wav_riff_chunk_parser_tb;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PROFILE_BYTES = 250;
    localparam int MAX_REPORTS   = 100;
    localparam int HOLD_CYCLES   = 150;

    typedef enum logic [2:0] {
        WALK_RIFF,
        WALK_HEADER,
        WALK_BODY,
        WALK_PAD,
        WALK_STOPPED,
        WALK_DONE
    } walk_phase_t;

    typedef enum {CK_DATA, CK_FMT, CK_OTHER} chunk_kind_t;

    // Tracks the chunk walk of the file and the output items it must produce
    class wav_walk_scoreboard;
        bit [31:0]      file_len;
        bit [31:0]      pos;
        walk_phase_t    phase = WALK_RIFF;
        bit [31:0]      tag_shift;
        bit [31:0]      chunk_size;
        bit [31:0]      chunk_off;
        bit [15:0]      fmt_code;
        bit [15:0]      chans;
        bit [31:0]      rate;
        bit [15:0]      bits;
        bit [3:0]       flags;
        wrc_pkg::item_t due_items[$];
        int             errors;

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Move to the next chunk header if it still fits in the file
        function void open_header(longint unsigned at);
            if (at + 8 <= {32'd0, file_len})
            begin
                phase     = WALK_HEADER;
                chunk_off = 0;
            end
            else
                phase = WALK_STOPPED;
        endfunction

        function logic [wrc_pkg::STATUS_W-1:0] verdict_code();
            if (file_len < wrc_pkg::MIN_FILE)
                return wrc_pkg::ST_SHORT;
            if (!flags[wrc_pkg::FL_TAGS])
                return wrc_pkg::ST_BAD_TAGS;
            if (!flags[wrc_pkg::FL_FMT])
                return wrc_pkg::ST_NO_FMT;
            if (!flags[wrc_pkg::FL_DATA] || !flags[wrc_pkg::FL_FULL])
                return wrc_pkg::ST_NO_DATA;
            if (fmt_code != 16'd1 || bits != 16'd16)
                return wrc_pkg::ST_BAD_FMT;
            if (chans < 16'd1 || chans > 16'd2)
                return wrc_pkg::ST_BAD_CHANS;
            if (rate == 32'd0)
                return wrc_pkg::ST_ZERO_RATE;
            return wrc_pkg::ST_OK;
        endfunction

        // Advance the walk by one accepted file byte
        function void walk_byte(bit [7:0] b, bit last);
            longint unsigned next_pos;
            int unsigned     k;
            wrc_pkg::item_t  out_item;
            if (phase == WALK_DONE)
                return;
            next_pos = pos;
            next_pos = next_pos + 1;
            case (phase)
                WALK_RIFF:
                begin
                    tag_shift = {b, tag_shift[31:8]};
                    if (pos == 32'd3)
                    begin
                        if (tag_shift == wrc_pkg::TAG_RIFF)
                            flags[wrc_pkg::FL_TAGS] = 1'b1;
                    end
                    else if (pos == 32'd11)
                    begin
                        if (tag_shift != wrc_pkg::TAG_WAVE)
                            flags[wrc_pkg::FL_TAGS] = 1'b0;
                        if (file_len < wrc_pkg::MIN_FILE || !flags[wrc_pkg::FL_TAGS])
                        begin
                            flags[wrc_pkg::FL_TAGS] = 1'b0;
                            phase = WALK_STOPPED;
                        end
                        else
                            open_header(64'd12);
                    end
                end
                WALK_HEADER:
                begin
                    if (chunk_off < 4)
                        tag_shift = {b, tag_shift[31:8]};
                    else
                        chunk_size = {b, chunk_size[31:8]};
                    chunk_off++;
                    if (chunk_off == 8)
                    begin
                        chunk_off = 0;
                        if (next_pos + chunk_size > {32'd0, file_len})
                            phase = WALK_STOPPED;
                        else
                        begin
                            if (tag_shift == wrc_pkg::TAG_DATA)
                            begin
                                flags[wrc_pkg::FL_DATA] = 1'b1;
                                flags[wrc_pkg::FL_FULL] = (chunk_size != 0);
                            end
                            if (chunk_size == 0)
                                open_header(next_pos);
                            else
                                phase = WALK_BODY;
                        end
                    end
                end
                WALK_BODY:
                begin
                    if (tag_shift == wrc_pkg::TAG_DATA)
                    begin
                        out_item = '0;
                        out_item.item_kind    = wrc_pkg::KIND_PAYLOAD;
                        out_item.payload_byte = b;
                        out_item.run_start    = (chunk_off == 0);
                        due_items.push_back(out_item);
                    end
                    else if (tag_shift == wrc_pkg::TAG_FMT && chunk_size >= wrc_pkg::FMT_MIN
                             && chunk_off < wrc_pkg::FMT_MIN)
                    begin
                        k = chunk_off;
                        if (k < 2)
                            fmt_code[8*k +: 8] = b;
                        else if (k < 4)
                            chans[8*(k-2) +: 8] = b;
                        else if (k < 8)
                            rate[8*(k-4) +: 8] = b;
                        else if (k >= 14)
                            bits[8*(k-14) +: 8] = b;
                        if (k == wrc_pkg::FMT_MIN - 1)
                            flags[wrc_pkg::FL_FMT] = 1'b1;
                    end
                    chunk_off++;
                    if (chunk_off == chunk_size)
                    begin
                        chunk_off = 0;
                        if (chunk_size[0])
                            phase = WALK_PAD;
                        else
                            open_header(next_pos);
                    end
                end
                WALK_PAD:
                    open_header(next_pos);
                default:
                    ;
            endcase
            if (pos != 32'hFFFF_FFFF)
                pos++;
            if (last)
            begin
                out_item = '0;
                out_item.item_kind     = wrc_pkg::KIND_VERDICT;
                out_item.status        = verdict_code();
                out_item.channel_count = chans;
                out_item.sample_rate   = rate;
                out_item.last_result   = 1'b1;
                due_items.push_back(out_item);
                phase = WALK_DONE;
            end
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // Match one output request against the oldest expected item
        task check_item(wrc_pkg::item_t got);
            wrc_pkg::item_t want;
            if (due_items.size() == 0)
            begin
                report($sformatf("unexpected item kind %0d byte %02h",
                                 got.item_kind, got.payload_byte));
                return;
            end
            want = due_items.pop_front();
            compare_field("item_kind", got.item_kind, want.item_kind);
            compare_field("payload_byte", got.payload_byte, want.payload_byte);
            compare_field("run_start", got.run_start, want.run_start);
            compare_field("status", got.status, want.status);
            compare_field("channel_count", got.channel_count, want.channel_count);
            compare_field("sample_rate", got.sample_rate, want.sample_rate);
            compare_field("last_result", got.last_result, want.last_result);
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [wrc_pkg::CFG_W-1:0]   cfg_data;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [wrc_pkg::BYTE_W-1:0]  s_axis_tdata;
    logic                        s_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [wrc_pkg::TDATA_W-1:0] m_axis_tdata;
    logic                        m_axis_tuser;
    logic                        m_axis_tlast;

    wrc_pkg::item_t      seen_item;
    wav_walk_scoreboard  tracker;
    bit [7:0]            chunk_q[$];
    int unsigned         sender_idle_pct;
    int unsigned         recv_stall_pct;
    int unsigned         hold_request;
    int unsigned         bytes_sent;

    wav_riff_chunk_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Unpack the output request into its fields
    always_comb
    begin
        seen_item               = '0;
        seen_item.item_kind     = m_axis_tuser;
        seen_item.payload_byte  = m_axis_tdata[7:0];
        seen_item.run_start     = m_axis_tdata[8];
        seen_item.status        = m_axis_tdata[11:9];
        seen_item.channel_count = m_axis_tdata[27:12];
        seen_item.sample_rate   = m_axis_tdata[59:28];
        seen_item.last_result   = m_axis_tlast;
    end

    // Observe every request on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.file_len = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                tracker.walk_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_item(seen_item);
        end
    end

    // Drive the output ready: random stalls plus an occasional long hold-off
    initial
    begin
        int unsigned hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when no request moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic write_length(input bit [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input bit [7:0] value, input bit last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_word(input bit [31:0] word);
        for (int i = 0; i < 4; i++)
            send_byte(word[8*i +: 8], 1'b0);
    endtask

    // Hold the input idle until every expected item is out, then let it settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.due_items.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Assemble id, little-endian size, body and pad of one chunk
    task automatic build_chunk(input chunk_kind_t kind, input bit [31:0] body_len);
        bit [31:0]  tag;
        bit [127:0] fmt_image;
        chunk_q.delete();
        fmt_image = {$urandom(), $urandom(), $urandom(), $urandom()};
        if ($urandom_range(99) < 80)
            fmt_image[15:0] = 16'd1;
        if ($urandom_range(99) < 70)
            fmt_image[31:16] = 16'($urandom_range(2, 1));
        if ($urandom_range(99) < 10)
            fmt_image[63:32] = 32'd0;
        if ($urandom_range(99) < 80)
            fmt_image[127:112] = 16'd16;
        case (kind)
            CK_DATA: tag = wrc_pkg::TAG_DATA;
            CK_FMT:  tag = wrc_pkg::TAG_FMT;
            default:
                if ($urandom_range(1) == 1)
                    tag = $urandom();
                else
                    tag = wrc_pkg::TAG_DATA ^ (32'd1 << $urandom_range(31));
        endcase
        for (int i = 0; i < 4; i++)
            chunk_q.push_back(tag[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            chunk_q.push_back(body_len[8*i +: 8]);
        for (int i = 0; i < body_len; i++)
        begin
            if (kind == CK_FMT && i < 16)
                chunk_q.push_back(fmt_image[8*i +: 8]);
            else
                chunk_q.push_back(8'($urandom_range(255)));
        end
        if (body_len[0])
            chunk_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_chunk(input int count);
        for (int i = 0; i < count && i < chunk_q.size(); i++)
            send_byte(chunk_q[i], 1'b0);
    endtask

    task automatic send_random_chunk();
        int unsigned pick;
        int unsigned saved_idle;
        int unsigned saved_stall;
        chunk_kind_t kind;
        bit [31:0]   body_len;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            kind     = CK_DATA;
            body_len = $urandom_range(24, 0);
        end
        else if (pick < 65)
        begin
            kind = CK_FMT;
            case ($urandom_range(3))
                0:       body_len = $urandom_range(15, 0);
                3:       body_len = $urandom_range(40, 17);
                default: body_len = wrc_pkg::FMT_MIN;
            endcase
        end
        else
        begin
            kind     = CK_OTHER;
            body_len = $urandom_range(20, 0);
        end
        build_chunk(kind, body_len);
        // Run some chunks with no idling on either side
        saved_idle  = sender_idle_pct;
        saved_stall = recv_stall_pct;
        if ($urandom_range(4) == 0)
        begin
            sender_idle_pct = 0;
            recv_stall_pct  = 0;
        end
        send_chunk(chunk_q.size());
        sender_idle_pct = saved_idle;
        recv_stall_pct  = saved_stall;
    endtask

    initial
    begin
        int unsigned idle_plan[4];
        int unsigned stall_plan[4];
        int unsigned stop_at;
        int unsigned mode;
        bit [31:0]   len;
        tracker         = new();
        idle_plan       = '{0, 77, 0, 38};
        stall_plan      = '{0, 0, 77, 38};
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_request    = 0;
        bytes_sent      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header tags under both length extremes, then an empty and an odd data chunk
        write_length(32'h0);
        send_word(wrc_pkg::TAG_RIFF);
        wait_drained();
        write_length(32'hFFFF_FFFF);
        send_word($urandom());
        send_word(wrc_pkg::TAG_WAVE);
        build_chunk(CK_DATA, 0);
        send_chunk(chunk_q.size());
        build_chunk(CK_DATA, 3);
        chunk_q[8]  = 8'h00;
        chunk_q[9]  = 8'hFF;
        chunk_q[10] = 8'h5A;
        send_chunk(chunk_q.size());

        // Random chunk walk under each idling profile
        for (int profile = 0; profile < 4; profile++)
        begin
            sender_idle_pct = idle_plan[profile];
            recv_stall_pct  = stall_plan[profile];
            stop_at         = bytes_sent + PROFILE_BYTES;
            if (profile == 0)
            begin
                // Back up the result queue into the input
                hold_request = HOLD_CYCLES;
                build_chunk(CK_DATA, 32);
                send_chunk(chunk_q.size());
            end
            while (bytes_sent < stop_at)
                send_random_chunk();
            wait_drained();
            write_length($urandom_range(32'hFFFF_FFFF, 32'h0100_0000));
        end

        // Close the walk: overrun, short tail, or end inside a chunk
        sender_idle_pct = 38;
        recv_stall_pct  = 38;
        mode = $urandom_range(2);
        if (mode == 0)
        begin
            len = bytes_sent + $urandom_range(40, 8);
            @(posedge clk);
            write_length(len);
            build_chunk(CK_DATA, len - bytes_sent - 8 + $urandom_range(12, 1));
            send_chunk(8 + $urandom_range(4));
        end
        else if (mode == 1)
        begin
            build_chunk(chunk_kind_t'($urandom_range(2)), $urandom_range(20, 1));
            send_chunk(chunk_q.size() - 1);
            wait_drained();
            write_length(bytes_sent + 1 + $urandom_range(7));
            send_byte(chunk_q[chunk_q.size() - 1], 1'b0);
            repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), 1'b0);
        end
        else
        begin
            build_chunk(chunk_kind_t'($urandom_range(2)), $urandom_range(24, 1));
            send_chunk($urandom_range(chunk_q.size() - 1, 1));
        end
        if ($urandom_range(3) == 0)
        begin
            wait_drained();
            write_length($urandom_range(43, 0));
        end
        send_byte(8'($urandom_range(255)), 1'b1);

        // Bytes after the verdict are dropped
        repeat ($urandom_range(6, 2)) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        wait_drained();

        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/wrc_pkg.sv
src/wrc_front.sv
src/wrc_queue.sv
src/wrc_back.sv
src/wav_riff_chunk_parser.sv
verif/wav_riff_chunk_parser_tb.sv
